// ----- hw/rtl/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// psc_pkg - shared types and constants for the predictive step-size controller
// Log2-domain fixed-point formats, register indexes, configuration bundle,
// history bundle and the order-to-exponent table.
// ----------------------------------------------------------------------------
package psc_pkg;

    // data formats
    localparam int DATA_W          = 24;
    localparam int FRAC_BITS       = 16;
    localparam int SHOW_W          = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int ORDER_W         = 3;
    localparam int EXP_W           = 17;
    localparam int EXP_FRAC        = 16;
    localparam int CFG_INDEX_W     = 3;

    // request commands
    localparam logic CMD_ESTIMATE = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOG_TOLERANCE  = 3'd0,
        REG_METHOD_ORDER   = 3'd1,
        REG_LOG_RATIO_MAX  = 3'd2,
        REG_LOG_RATIO_MIN  = 3'd3,
        REG_LOG_SAFETY     = 3'd4,
        REG_USE_PREDICTIVE = 3'd5
    } reg_index_t;

    // reset values of the configuration registers
    localparam logic signed [DATA_W-1:0] TOLERANCE_RST = 24'sd0;
    localparam logic [ORDER_W-1:0]       ORDER_RST     = 3'd3;
    localparam logic signed [DATA_W-1:0] RATIO_MAX_RST = 24'sd169403;
    localparam logic signed [DATA_W-1:0] RATIO_MIN_RST = -24'sd152170;
    localparam logic signed [DATA_W-1:0] SAFETY_RST    = -24'sd9962;
    localparam logic                     PREDICT_RST   = 1'b1;

    // error floor log2(0.01), held with 24 fraction bits, rounded to FRAC_BITS
    localparam int FLOOR_Q24_MAG = 111465410;
    localparam int FLOOR_SHIFT   = 24 - FRAC_BITS;
    localparam int FLOOR_HALF    = (FLOOR_SHIFT > 0) ? (1 << (FLOOR_SHIFT - 1)) : 0;
    localparam logic signed [DATA_W-1:0] LOG_ERR_FLOOR =
        DATA_W'(-((FLOOR_Q24_MAG + FLOOR_HALF) >>> FLOOR_SHIFT));

    typedef struct packed {
        logic signed [DATA_W-1:0] log_tolerance;
        logic [ORDER_W-1:0]       method_order;
        logic signed [DATA_W-1:0] log_ratio_max;
        logic signed [DATA_W-1:0] log_ratio_min;
        logic signed [DATA_W-1:0] log_safety;
        logic                     use_predictive;
    } cfg_t;

    // last accepted step and error, plus history flag
    typedef struct packed {
        logic signed [DATA_W-1:0] log_step;
        logic signed [DATA_W-1:0] log_error;
        logic                     valid;
    } hist_t;

    // exponent 1/(p+1), 16 fraction bits, rounded to nearest
    function automatic logic [EXP_W-1:0] exp_of(input logic [ORDER_W-1:0] order);
        logic [EXP_W-1:0] pw;
        case (order)
            3'd0:    pw = 17'd65536;
            3'd1:    pw = 17'd32768;
            3'd2:    pw = 17'd21845;
            3'd3:    pw = 17'd16384;
            3'd4:    pw = 17'd13107;
            3'd5:    pw = 17'd10923;
            3'd6:    pw = 17'd9362;
            default: pw = 17'd8192;
        endcase
        return pw;
    endfunction

endpackage

// ----- hw/rtl/psc_cfg.sv -----
// ----------------------------------------------------------------------------
// psc_cfg - configuration register file
// Six write-only registers with reset defaults; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module psc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [psc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psc_pkg::DATA_W-1:0]       cfg_data,
    output psc_pkg::cfg_t                    cfg
);
    import psc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LOG_TOLERANCE:  cfg_next.log_tolerance  = signed'(cfg_data);
                REG_METHOD_ORDER:   cfg_next.method_order   = cfg_data[ORDER_W-1:0];
                REG_LOG_RATIO_MAX:  cfg_next.log_ratio_max  = signed'(cfg_data);
                REG_LOG_RATIO_MIN:  cfg_next.log_ratio_min  = signed'(cfg_data);
                REG_LOG_SAFETY:     cfg_next.log_safety     = signed'(cfg_data);
                REG_USE_PREDICTIVE: cfg_next.use_predictive = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage with defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.log_tolerance  <= TOLERANCE_RST;
            cfg_reg.method_order   <= ORDER_RST;
            cfg_reg.log_ratio_max  <= RATIO_MAX_RST;
            cfg_reg.log_ratio_min  <= RATIO_MIN_RST;
            cfg_reg.log_safety     <= SAFETY_RST;
            cfg_reg.use_predictive <= PREDICT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/psc_calc.sv -----
// ----------------------------------------------------------------------------
// psc_calc - step ratio datapath
// Accept test, standard ratio with clamps, predictive ratio, proposed
// step with saturation, and next history and counter values.
// ----------------------------------------------------------------------------
module psc_calc #(
    parameter int COUNT_WIDTH = psc_pkg::COUNT_WIDTH_DEF
) (
    input  psc_pkg::cfg_t                           cfg,
    input  logic                                    cmd,
    input  logic signed [psc_pkg::DATA_W-1:0]       log_error,
    input  logic signed [psc_pkg::DATA_W-1:0]       log_step,
    input  psc_pkg::hist_t                          hist,
    input  logic [COUNT_WIDTH-1:0]                  acc_count,
    input  logic [COUNT_WIDTH-1:0]                  rej_count,
    output psc_pkg::hist_t                          hist_next,
    output logic [COUNT_WIDTH-1:0]                  acc_next,
    output logic [COUNT_WIDTH-1:0]                  rej_next,
    output logic signed [psc_pkg::DATA_W-1:0]       log_next_step,
    output logic                                    step_ok,
    output logic                                    used_prediction
);
    import psc_pkg::*;

    localparam int W = 32;

    // x * 2^-EXP_FRAC * pw, rounded to nearest with ties upward
    function automatic logic signed [W-1:0] mul_exp(
        input logic signed [DATA_W+1:0] x,
        input logic [EXP_W-1:0]         pw
    );
        logic signed [DATA_W+EXP_W+2:0] prod;
        prod = x * signed'({1'b0, pw});
        prod = prod + (DATA_W+EXP_W+3)'(1 << (EXP_FRAC - 1));
        return W'(prod >>> EXP_FRAC);
    endfunction

    logic [EXP_W-1:0]        pw;
    logic signed [W-1:0]     s_w, saf_w, hi_w, lo_w;
    logic signed [W-1:0]     r_std, r_hi, r_clamp, r_pred, r_sel, nxt;
    logic signed [DATA_W+1:0] pred_arg;
    logic                    ok, pred, est;
    logic [COUNT_WIDTH-1:0]  acc_inc, rej_inc;

    assign pw    = exp_of(cfg.method_order);
    assign s_w   = W'(log_step);
    assign saf_w = W'(cfg.log_safety);
    assign hi_w  = -W'(cfg.log_ratio_min);
    assign lo_w  = -W'(cfg.log_ratio_max);
    assign est   = (cmd == CMD_ESTIMATE);
    assign ok    = log_error < cfg.log_tolerance;

    // saturating counters
    assign acc_inc = (&acc_count) ? acc_count : acc_count + COUNT_WIDTH'(1);
    assign rej_inc = (&rej_count) ? rej_count : rej_count + COUNT_WIDTH'(1);

    // standard ratio, upper clamp then lower clamp
    assign r_std   = mul_exp((DATA_W+2)'(log_error), pw) - saf_w;
    assign r_hi    = (r_std > hi_w) ? hi_w : r_std;
    assign r_clamp = (r_hi < lo_w) ? lo_w : r_hi;

    // predictive ratio from the last accepted step
    assign pred_arg = ((DATA_W+2)'(log_error) <<< 1) - (DATA_W+2)'(hist.log_error);
    assign r_pred   = (W'(hist.log_step) - s_w) + mul_exp(pred_arg, pw) - saf_w;
    assign pred     = ok && cfg.use_predictive && hist.valid && (acc_inc > COUNT_WIDTH'(1));
    assign r_sel    = (pred && (r_pred > r_clamp)) ? r_pred : r_clamp;

    // proposed step with saturation, zero on a clear
    assign nxt = s_w - r_sel;

    always_comb
    begin
        if (!est)
            log_next_step = '0;
        else if (nxt > W'(24'sh7FFFFF))
            log_next_step = 24'sh7FFFFF;
        else if (nxt < -W'(25'sh800000))
            log_next_step = 24'sh800000;
        else
            log_next_step = DATA_W'(nxt);
    end

    assign step_ok         = est && ok;
    assign used_prediction = est && pred;

    // next history and counters
    always_comb
    begin
        if (!est)
        begin
            hist_next = '0;
            acc_next  = '0;
            rej_next  = '0;
        end
        else
        begin
            hist_next       = hist;
            hist_next.valid = 1'b1;
            acc_next        = ok ? acc_inc : acc_count;
            rej_next        = ok ? rej_count : rej_inc;
            if (ok && cfg.use_predictive)
            begin
                hist_next.log_step  = log_step;
                hist_next.log_error = (log_error > LOG_ERR_FLOOR) ? log_error : LOG_ERR_FLOOR;
            end
        end
    end

endmodule

// ----- hw/rtl/predictive_step_size_controller_top.sv -----
// ----------------------------------------------------------------------------
// predictive_step_size_controller_top - log2-domain step-size controller
// Error-per-step controller with an optional predictive estimate, history
// of the last accepted step, and saturating accept and reject counts.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in        request    in_valid / in_stall    cmd, log_error, log_step
//   out       result     out_valid / out_stall  log_next_step, step_ok,
//                                               accepted_total, rejected_total,
//                                               used_prediction
//   cfg       write      cfg_write              cfg_index, cfg_data
//
// One request per cycle sustained while the result is not stalled; a taken
// request passes through the input register, then the ratio datapath into
// the result register. History and counts update as a request moves into
// the result register, so the following request sees them with no bubble.
// Reset loads the default configuration and clears history and counts.
// A stalled result holds the result register; a full input register then
// holds and in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module predictive_step_size_controller_top #(
    parameter int COUNT_WIDTH = psc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    cmd,
    input  logic signed [psc_pkg::DATA_W-1:0]       log_error,
    input  logic signed [psc_pkg::DATA_W-1:0]       log_step,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [psc_pkg::DATA_W-1:0]       log_next_step,
    output logic                                    step_ok,
    output logic [psc_pkg::SHOW_W-1:0]              accepted_total,
    output logic [psc_pkg::SHOW_W-1:0]              rejected_total,
    output logic                                    used_prediction,
    input  logic                                    cfg_write,
    input  logic [psc_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [psc_pkg::DATA_W-1:0]              cfg_data
);
    import psc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > SHOW_W) ? COUNT_WIDTH : SHOW_W;

    cfg_t cfg;

    // input register
    logic                     s1_valid_reg;
    logic                     s1_cmd_reg;
    logic signed [DATA_W-1:0] s1_err_reg;
    logic signed [DATA_W-1:0] s1_step_reg;

    // history and counters
    hist_t                    hist_reg, hist_next;
    logic [COUNT_WIDTH-1:0]   acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0]   rej_reg, rej_next;

    // result register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] next_step_reg, next_step_next;
    logic                     ok_reg, ok_next;
    logic                     pred_reg, pred_next;
    logic [SHOW_W-1:0]        acc_show_reg, acc_show_next;
    logic [SHOW_W-1:0]        rej_show_reg, rej_show_next;

    logic s1_adv, s1_move, in_take;

    psc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psc_calc #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_calc (
        .cfg             (cfg),
        .cmd             (s1_cmd_reg),
        .log_error       (s1_err_reg),
        .log_step        (s1_step_reg),
        .hist            (hist_reg),
        .acc_count       (acc_reg),
        .rej_count       (rej_reg),
        .hist_next       (hist_next),
        .acc_next        (acc_next),
        .rej_next        (rej_next),
        .log_next_step   (next_step_next),
        .step_ok         (ok_next),
        .used_prediction (pred_next)
    );

    // pipeline flow control
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    // counts shown saturated at the output width
    always_comb
    begin
        acc_show_next = (CMP_W'(acc_next) > CMP_W'({SHOW_W{1'b1}})) ?
                        {SHOW_W{1'b1}} : SHOW_W'(acc_next);
        rej_show_next = (CMP_W'(rej_next) > CMP_W'({SHOW_W{1'b1}})) ?
                        {SHOW_W{1'b1}} : SHOW_W'(rej_next);
    end

    // control and history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
            acc_reg       <= '0;
            rej_reg       <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
                hist_reg      <= hist_next;
                acc_reg       <= acc_next;
                rej_reg       <= rej_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg  <= cmd;
            s1_err_reg  <= log_error;
            s1_step_reg <= log_step;
        end
        if (s1_move)
        begin
            next_step_reg <= next_step_next;
            ok_reg        <= ok_next;
            pred_reg      <= pred_next;
            acc_show_reg  <= acc_show_next;
            rej_show_reg  <= rej_show_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign log_next_step   = next_step_reg;
    assign step_ok         = ok_reg;
    assign used_prediction = pred_reg;
    assign accepted_total  = acc_show_reg;
    assign rejected_total  = rej_show_reg;

endmodule

// ----- hw/rtl/psc_checker.sv -----
// ----------------------------------------------------------------------------
// psc_checker - port-level checks for the step-size controller
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module psc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [psc_pkg::DATA_W-1:0]  log_next_step,
    input logic                               step_ok,
    input logic [psc_pkg::SHOW_W-1:0]         accepted_total,
    input logic                               used_prediction
);
    import psc_pkg::*;

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(log_next_step))
        else $error("stalled result changed");

    // requests back up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a stalled result");

    // prediction only on accepted steps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && used_prediction |-> step_ok)
        else $error("prediction on a rejected step");

    // prediction needs an earlier accepted step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && used_prediction |-> accepted_total > SHOW_W'(1))
        else $error("prediction without an earlier accepted step");

endmodule

bind predictive_step_size_controller_top psc_checker u_psc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .log_next_step   (log_next_step),
    .step_ok         (step_ok),
    .accepted_total  (accepted_total),
    .used_prediction (used_prediction)
);

// ----- tb/sv/psc_step_checker.sv -----
// ----------------------------------------------------------------------------
// psc_step_checker - result checker for the predictive step-size controller
// Watches the request, result and register-write ports, keeps its own copy
// of the controller history and settings, predicts each result and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module psc_step_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                cmd,
    input  logic signed [psc_pkg::DATA_W-1:0]   log_error,
    input  logic signed [psc_pkg::DATA_W-1:0]   log_step,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [psc_pkg::DATA_W-1:0]   log_next_step,
    input  logic                                step_ok,
    input  logic [psc_pkg::SHOW_W-1:0]          accepted_total,
    input  logic [psc_pkg::SHOW_W-1:0]          rejected_total,
    input  logic                                used_prediction,
    input  logic                                cfg_write,
    input  logic [psc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [psc_pkg::DATA_W-1:0]          cfg_data,
    output int                                  mismatch_count,
    output int                                  open_requests
);
    import psc_pkg::*;

    // log2(0.01) with 24 fraction bits, rounded to nearest at FRAC_BITS
    localparam longint FLOOR_Q24      = 111465410;
    localparam int     FLOOR_DROP     = 24 - FRAC_BITS;
    localparam longint FLOOR_ROUND    = (FLOOR_DROP > 0) ? (64'sd1 <<< (FLOOR_DROP - 1)) : 0;
    localparam longint ERROR_FLOOR    = -((FLOOR_Q24 + FLOOR_ROUND) >>> FLOOR_DROP);
    localparam longint STEP_MAX       = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint STEP_MIN       = -(64'sd1 <<< (DATA_W - 1));

    typedef struct packed {
        logic [DATA_W-1:0] next_step;
        logic              ok;
        logic [SHOW_W-1:0] accepted;
        logic [SHOW_W-1:0] rejected;
        logic              predicted;
    } step_result_t;

    // settings as the block holds them
    logic signed [DATA_W-1:0] tolerance   = TOLERANCE_RST;
    logic [ORDER_W-1:0]       order       = ORDER_RST;
    logic signed [DATA_W-1:0] growth_max  = RATIO_MAX_RST;
    logic signed [DATA_W-1:0] shrink_min  = RATIO_MIN_RST;
    logic signed [DATA_W-1:0] safety      = SAFETY_RST;
    logic                     predictive  = PREDICT_RST;

    // controller history
    logic signed [DATA_W-1:0] prior_step  = '0;
    logic signed [DATA_W-1:0] prior_error = '0;
    logic [SHOW_W-1:0]        accepts     = '0;
    logic [SHOW_W-1:0]        rejects     = '0;
    logic                     have_history = 1'b0;

    step_result_t expected_steps[$];
    int           failures = 0;

    initial mismatch_count = 0;
    initial open_requests  = 0;

    // 1/(p+1) with 16 fraction bits
    function automatic longint order_exponent(input logic [ORDER_W-1:0] p);
        case (p)
            3'd0:    return 65536;
            3'd1:    return 32768;
            3'd2:    return 21845;
            3'd3:    return 16384;
            3'd4:    return 13107;
            3'd5:    return 10923;
            3'd6:    return 9362;
            default: return 8192;
        endcase
    endfunction

    // x times the exponent, rounded half up back to FRAC_BITS
    function automatic longint scale_by_order(input longint x);
        longint prod;
        prod = x * order_exponent(order);
        return (prod + (64'sd1 <<< (EXP_FRAC - 1))) >>> EXP_FRAC;
    endfunction

    task automatic predict_next_step(input logic c,
                                     input logic signed [DATA_W-1:0] err,
                                     input logic signed [DATA_W-1:0] step);
        step_result_t res;
        longint       e;
        longint       s;
        longint       ratio;
        longint       ratio_pred;
        longint       next;
        logic         ok;
        logic         pred;
        res  = '0;
        pred = 1'b0;
        if (c == CMD_CLEAR) begin
            prior_step   = '0;
            prior_error  = '0;
            accepts      = '0;
            rejects      = '0;
            have_history = 1'b0;
        end else begin
            e  = longint'(err);
            s  = longint'(step);
            ok = (e < longint'(tolerance));

            // standard ratio, upper clamp then lower clamp
            ratio = scale_by_order(e) - longint'(safety);
            if (ratio > -longint'(shrink_min))
                ratio = -longint'(shrink_min);
            if (ratio < -longint'(growth_max))
                ratio = -longint'(growth_max);

            if (ok) begin
                if (accepts != '1)
                    accepts = accepts + 1'b1;
                if (predictive) begin
                    if (accepts > 1 && have_history) begin
                        ratio_pred = (longint'(prior_step) - s)
                                   + scale_by_order(2 * e - longint'(prior_error))
                                   - longint'(safety);
                        if (ratio_pred > ratio)
                            ratio = ratio_pred;
                        pred = 1'b1;
                    end
                    prior_step  = step;
                    prior_error = (e > ERROR_FLOOR) ? err : DATA_W'(ERROR_FLOOR);
                end
            end else if (rejects != '1) begin
                rejects = rejects + 1'b1;
            end
            have_history = 1'b1;

            next = s - ratio;
            if (next > STEP_MAX)
                next = STEP_MAX;
            if (next < STEP_MIN)
                next = STEP_MIN;

            res.next_step = DATA_W'(next);
            res.ok        = ok;
            res.accepted  = accepts;
            res.rejected  = rejects;
            res.predicted = pred;
        end
        expected_steps.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n) begin
        step_result_t want;
        if (!rst_n) begin
            tolerance    = TOLERANCE_RST;
            order        = ORDER_RST;
            growth_max   = RATIO_MAX_RST;
            shrink_min   = RATIO_MIN_RST;
            safety       = SAFETY_RST;
            predictive   = PREDICT_RST;
            prior_step   = '0;
            prior_error  = '0;
            accepts      = '0;
            rejects      = '0;
            have_history = 1'b0;
            expected_steps.delete();
        end else begin
            // register writes
            if (cfg_write) begin
                case (reg_index_t'(cfg_index))
                    REG_LOG_TOLERANCE:  tolerance  = cfg_data;
                    REG_METHOD_ORDER:   order      = cfg_data[ORDER_W-1:0];
                    REG_LOG_RATIO_MAX:  growth_max = cfg_data;
                    REG_LOG_RATIO_MIN:  shrink_min = cfg_data;
                    REG_LOG_SAFETY:     safety     = cfg_data;
                    REG_USE_PREDICTIVE: predictive = cfg_data[0];
                    default: ;
                endcase
            end

            // compare a returned result with the oldest prediction
            if (out_valid && !out_stall) begin
                if (expected_steps.size() == 0) begin
                    $error("result returned with no request outstanding");
                    failures++;
                end else begin
                    want = expected_steps.pop_front();
                    if (log_next_step !== want.next_step) begin
                        $error("log_next_step: expected %0d, actual %0d",
                               $signed(want.next_step), $signed(log_next_step));
                        failures++;
                    end
                    if (step_ok !== want.ok) begin
                        $error("step_ok: expected %0d, actual %0d", want.ok, step_ok);
                        failures++;
                    end
                    if (accepted_total !== want.accepted) begin
                        $error("accepted_total: expected %0d, actual %0d",
                               want.accepted, accepted_total);
                        failures++;
                    end
                    if (rejected_total !== want.rejected) begin
                        $error("rejected_total: expected %0d, actual %0d",
                               want.rejected, rejected_total);
                        failures++;
                    end
                    if (used_prediction !== want.predicted) begin
                        $error("used_prediction: expected %0d, actual %0d",
                               want.predicted, used_prediction);
                        failures++;
                    end
                end
            end

            // predict each accepted request
            if (in_valid && !in_stall)
                predict_next_step(cmd, log_error, log_step);
        end
        mismatch_count <= failures;
        open_requests  <= expected_steps.size();
    end

endmodule

// ----- tb/sv/predictive_step_size_controller_top_tb.sv -----
// ----------------------------------------------------------------------------
// predictive_step_size_controller_top_tb - testbench for the step-size controller
// Drives directed and random step requests across a range of register
// settings, with random idle bursts on both channels, ends with a run at
// full rate, and gives the verdict from the checker's mismatch and open counts.
// ----------------------------------------------------------------------------
module predictive_step_size_controller_top_tb;
    import psc_pkg::*;

    localparam int     HANG_LIMIT   = 1000;
    localparam longint Q16_ONE      = 65536;
    localparam longint DATA_MAX     = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint DATA_MIN     = -(64'sd1 <<< (DATA_W - 1));
    localparam int     PHASE_ITEMS  = 150;

    logic                     clk;
    logic                     rst_n           = 1'b0;
    logic                     in_valid        = 1'b0;
    logic                     in_stall;
    logic                     cmd             = CMD_ESTIMATE;
    logic signed [DATA_W-1:0] log_error       = '0;
    logic signed [DATA_W-1:0] log_step        = '0;
    logic                     out_valid;
    logic                     out_stall       = 1'b0;
    logic signed [DATA_W-1:0] log_next_step;
    logic                     step_ok;
    logic [SHOW_W-1:0]        accepted_total;
    logic [SHOW_W-1:0]        rejected_total;
    logic                     used_prediction;
    logic                     cfg_write       = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index       = '0;
    logic [DATA_W-1:0]        cfg_data        = '0;
    int                       mismatch_count;
    int                       open_requests;

    logic   idle_enable    = 1'b1;
    longint tolerance_now  = 0;

    predictive_step_size_controller_top DUT (.*);

    psc_step_checker checker_i (.*);

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stall bursts
    initial begin : receiver
        int burst;
        forever begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // hang detection: cycles with nothing moving on either channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("predictive_step_size_controller_top test failed");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] clamp_data(input longint v);
        if (v > DATA_MAX)
            return DATA_W'(DATA_MAX);
        if (v < DATA_MIN)
            return DATA_W'(DATA_MIN);
        return DATA_W'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] edge_value();
        case ($urandom_range(0, 3))
            0:       return DATA_W'(DATA_MIN);
            1:       return DATA_W'(DATA_MAX);
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // one request, with an optional idle gap before it
    task automatic send_request(input logic c,
                                input logic signed [DATA_W-1:0] err,
                                input logic signed [DATA_W-1:0] step);
        int gap;
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        log_error <= err;
        log_step  <= step;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // mostly errors near the tolerance, some wide and edge values
    task automatic send_random_request();
        int                       pick;
        logic                     c;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] step;
        pick = $urandom_range(0, 99);
        c    = (pick < 3) ? CMD_CLEAR : CMD_ESTIMATE;
        if (pick < 70) begin
            err  = clamp_data(tolerance_now
                              + longint'($urandom_range(0, 6 * Q16_ONE)) - 4 * Q16_ONE);
            step = clamp_data(longint'($urandom_range(0, 32 * Q16_ONE)) - 16 * Q16_ONE);
        end else if (pick < 90) begin
            err  = DATA_W'($urandom());
            step = DATA_W'($urandom());
        end else begin
            err  = edge_value();
            step = edge_value();
        end
        send_request(c, err, step);
    endtask

    // wait until every result is back, then let the pipeline empty
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_requests != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // narrow registers get random upper bits, which the block ignores
    task automatic load_settings(input longint tol, input int p, input longint growth,
                                 input longint shrink, input longint safety, input bit pred);
        logic [DATA_W-1:0] filler;
        filler = DATA_W'($urandom());
        write_register(REG_LOG_TOLERANCE, DATA_W'(tol));
        write_register(REG_METHOD_ORDER, {filler[DATA_W-1:ORDER_W], p[ORDER_W-1:0]});
        write_register(REG_LOG_RATIO_MAX, DATA_W'(growth));
        write_register(REG_LOG_RATIO_MIN, DATA_W'(shrink));
        write_register(REG_LOG_SAFETY, DATA_W'(safety));
        write_register(REG_USE_PREDICTIVE, {filler[DATA_W-1:1], pred});
        cfg_write     <= 1'b0;
        tolerance_now = tol;
    endtask

    task automatic load_random_settings();
        if ($urandom_range(0, 3) == 0) begin
            load_settings(longint'(clamp_data(longint'($urandom_range(0, 2 * Q16_ONE))
                                              - Q16_ONE + longint'($signed(24'($urandom()))) / 64)),
                          $urandom_range(0, 7),
                          longint'($signed(24'($urandom()))),
                          longint'($signed(24'($urandom()))),
                          longint'($signed(24'($urandom()))),
                          $urandom_range(0, 1));
        end else begin
            load_settings(longint'($urandom_range(0, 16 * Q16_ONE)) - 8 * Q16_ONE,
                          $urandom_range(0, 7),
                          longint'($urandom_range(0, 4 * Q16_ONE)),
                          -longint'($urandom_range(0, 4 * Q16_ONE)),
                          -longint'($urandom_range(0, Q16_ONE)),
                          $urandom_range(0, 4) != 0);
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests on the reset settings
        send_request(CMD_ESTIMATE, 24'sd0, 24'sd0);                  // error at tolerance
        send_request(CMD_ESTIMATE, -24'sd1, 24'sd0);                 // just below tolerance
        send_request(CMD_ESTIMATE, DATA_W'(DATA_MIN), DATA_W'(DATA_MAX));
        send_request(CMD_ESTIMATE, DATA_W'(DATA_MAX), DATA_W'(DATA_MIN));
        send_request(CMD_ESTIMATE, DATA_W'(DATA_MIN), DATA_W'(DATA_MIN)); // error floored
        send_request(CMD_ESTIMATE, -24'sd65536, 24'sd65536);         // uses floored error
        send_request(CMD_CLEAR, DATA_W'(DATA_MAX), -24'sd1);
        send_request(CMD_ESTIMATE, -24'sd131072, -24'sd65536);       // first accept, no history
        send_request(CMD_ESTIMATE, -24'sd131072, -24'sd65536);
        send_request(CMD_CLEAR, 24'sd0, 24'sd0);

        // accepts without prediction, then prediction on the cleared history
        drain_results();
        load_settings(TOLERANCE_RST, ORDER_RST, RATIO_MAX_RST, RATIO_MIN_RST, SAFETY_RST, 1'b0);
        send_request(CMD_ESTIMATE, -24'sd65536, 24'sd1000);
        send_request(CMD_ESTIMATE, -24'sd65536, 24'sd1000);
        drain_results();
        load_settings(TOLERANCE_RST, ORDER_RST, RATIO_MAX_RST, RATIO_MIN_RST, SAFETY_RST, 1'b1);
        send_request(CMD_ESTIMATE, -24'sd65536, -24'sd500);

        // random phases over several settings
        for (int phase = 0; phase < 9; phase++) begin
            drain_results();
            case (phase)
                0: load_settings(DATA_MIN, 0, DATA_MIN, DATA_MIN, DATA_MIN, 1'b0);
                1: load_settings(DATA_MAX, 7, DATA_MAX, DATA_MAX, DATA_MAX, 1'b1);
                2: load_settings(0, 3, -Q16_ONE, Q16_ONE, -9962, 1'b1);   // inverted limits
                default: load_random_settings();
            endcase
            repeat (PHASE_ITEMS) send_random_request();
        end

        // full-rate run, no idling from here on
        drain_results();
        idle_enable = 1'b0;
        load_random_settings();
        repeat (50) send_random_request();

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && open_requests == 0)
            $display("predictive_step_size_controller_top test passed");
        else
            $display("predictive_step_size_controller_top test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/psc_pkg.sv
hw/rtl/psc_cfg.sv
hw/rtl/psc_calc.sv
hw/rtl/predictive_step_size_controller_top.sv
hw/rtl/psc_checker.sv
tb/sv/psc_step_checker.sv
tb/sv/predictive_step_size_controller_top_tb.sv
